[design/kbd_pkg.sv]
// ----------------------------------------------------------------------------
// kbd_pkg
// Shared constants and types for the KISS byte deframer.
// ----------------------------------------------------------------------------
package kbd_pkg;

    localparam logic [7:0] FEND  = 8'hC0;
    localparam logic [7:0] FESC  = 8'hDB;
    localparam logic [7:0] TFEND = 8'hDC;
    localparam logic [7:0] TFESC = 8'hDD;

    // one result beat from the deframing core
    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        logic       is_port;
        logic       last;
    } kbd_res_t;

endpackage

[design/kbd_in_stage.sv]
// ----------------------------------------------------------------------------
// kbd_in_stage
// Input register: captures one received byte per beat.
// ----------------------------------------------------------------------------
module kbd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       consume,
    output logic       s1_valid,
    output logic [7:0] s1_byte
);
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       load;

    // the stage holds its byte until the core has taken it
    assign in_stall = valid_reg & ~consume;
    assign load     = in_valid & ~in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_byte  = byte_reg;
endmodule

[design/kbd_core.sv]
// ----------------------------------------------------------------------------
// kbd_core
// Framing state, unescape and one-byte hold; decides the result of each byte.
// ----------------------------------------------------------------------------
module kbd_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic [7:0]      rx_byte,
    output kbd_pkg::kbd_res_t res
);
    import kbd_pkg::*;

    logic       in_frame_reg,   in_frame_next;
    logic       in_escape_reg,  in_escape_next;
    logic       held_valid_reg, held_valid_next;
    logic [7:0] held_byte_reg,  held_byte_next;
    logic       held_first_reg, held_first_next;
    logic       any_emit_reg,   any_emit_next;
    logic [7:0] plain;
    logic       is_fend;
    logic       is_fesc;

    assign is_fend = (rx_byte == FEND);
    assign is_fesc = (rx_byte == FESC);

    always_comb
    begin
        plain = rx_byte;
        if (in_escape_reg)
        begin
            case (rx_byte)
                TFEND:   plain = FEND;
                TFESC:   plain = FESC;
                default: plain = rx_byte;
            endcase
        end
    end

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        in_escape_next  = in_escape_reg;
        held_valid_next = held_valid_reg;
        held_byte_next  = held_byte_reg;
        held_first_next = held_first_reg;
        any_emit_next   = any_emit_reg;
        res.emit        = 1'b0;
        res.data        = held_byte_reg;
        res.is_port     = held_first_reg;
        res.last        = 1'b0;
        if (is_fend)
        begin
            // closing FEND flushes the held byte as last
            res.emit        = in_frame_reg & held_valid_reg;
            res.last        = 1'b1;
            in_frame_next   = ~in_frame_reg;
            in_escape_next  = 1'b0;
            held_valid_next = 1'b0;
            held_byte_next  = 8'h00;
            held_first_next = 1'b0;
            any_emit_next   = 1'b0;
        end
        else if (in_frame_reg)
        begin
            if (is_fesc)
            begin
                in_escape_next = 1'b1;
            end
            else
            begin
                res.emit        = held_valid_reg;
                in_escape_next  = 1'b0;
                held_byte_next  = plain;
                held_first_next = ~any_emit_reg;
                any_emit_next   = 1'b1;
                held_valid_next = 1'b1;
            end
        end
        if (!fire)
        begin
            res.emit = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            in_escape_reg  <= 1'b0;
            held_valid_reg <= 1'b0;
            held_byte_reg  <= 8'h00;
            held_first_reg <= 1'b0;
            any_emit_reg   <= 1'b0;
        end
        else if (fire)
        begin
            in_frame_reg   <= in_frame_next;
            in_escape_reg  <= in_escape_next;
            held_valid_reg <= held_valid_next;
            held_byte_reg  <= held_byte_next;
            held_first_reg <= held_first_next;
            any_emit_reg   <= any_emit_next;
        end
    end
endmodule

[design/kbd_out_stage.sv]
// ----------------------------------------------------------------------------
// kbd_out_stage
// Result register: holds one frame byte beat until downstream takes it.
// ----------------------------------------------------------------------------
module kbd_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  kbd_pkg::kbd_res_t res,
    output logic              free,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        frame_byte,
    output logic              is_port,
    output logic              last
);
    import kbd_pkg::*;

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       port_reg;
    logic       last_reg;

    // register can take a new result when empty or being drained this cycle
    assign free = ~valid_reg | ~out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res.emit)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.emit)
        begin
            data_reg <= res.data;
            port_reg <= res.is_port;
            last_reg <= res.last;
        end
    end

    assign out_valid  = valid_reg;
    assign frame_byte = data_reg;
    assign is_port    = port_reg;
    assign last       = last_reg;
endmodule

[design/kiss_byte_deframer.sv]
// ----------------------------------------------------------------------------
// kiss_byte_deframer
// Strips KISS framing from a received byte stream, marks port and last bytes.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------
//  in      | in_valid / in_stall   | rx_byte[7:0]
//  out     | out_valid / out_stall | frame_byte[7:0], is_port, last
//
// One byte per cycle sustained while out_stall is low; kbd_core updates the
// framing state between the input register and the result register.
// A frame byte leaves once the next non-FESC byte or the closing FEND is
// taken (held until then); its result is valid in the cycle after that byte.
// Reset clears the framing state and both stage valid flags.
// A stalled output only blocks the input when a byte is waiting to be processed.
module kiss_byte_deframer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] frame_byte,
    output logic       is_port,
    output logic       last
);
    import kbd_pkg::*;

    logic       s1_valid;
    logic [7:0] s1_byte;
    logic       free;
    logic       fire;
    kbd_res_t   res;

    assign fire = s1_valid & free;

    kbd_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .consume  (fire),
        .s1_valid (s1_valid),
        .s1_byte  (s1_byte)
    );

    kbd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .rx_byte (s1_byte),
        .res     (res)
    );

    kbd_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .res        (res),
        .free       (free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .is_port    (is_port),
        .last       (last)
    );
endmodule

[design/kbd_checker.sv]
// ----------------------------------------------------------------------------
// kbd_sva
// Port-level checks for the KISS byte deframer, bound to the top level.
// ----------------------------------------------------------------------------
module kbd_sva (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] frame_byte,
    input logic       is_port,
    input logic       last
);
    logic out_beat;
    logic expect_port_reg;

    assign out_beat = out_valid & ~out_stall;

    // after reset or a last beat, the next beat must be a port byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_port_reg <= 1'b1;
        end
        else if (out_beat)
        begin
            expect_port_reg <= last;
        end
    end

    a_port_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> (is_port == expect_port_reg))
        else $error("port flag out of order");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output back-pressure");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(frame_byte)
            && $stable(is_port) && $stable(last)))
        else $error("stalled result changed");

    a_idle_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !$past(in_valid)) |-> !in_stall)
        else $error("input stalled while idle");
endmodule

bind kiss_byte_deframer kbd_sva u_kbd_sva (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_byte (frame_byte),
    .is_port    (is_port),
    .last       (last)
);

[dv/kbd_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kbd_checker
// Watches both channels of the KISS deframer, tracks the framing state from
// the accepted input beats and compares each output beat, field by field,
// with the oldest frame byte still owed.
// ----------------------------------------------------------------------------
module kbd_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] frame_byte,
    input  logic       is_port,
    input  logic       last,
    output int         fail_count,
    output int         pending,
    output int         bytes_in,
    output int         bytes_out,
    output int         frames_out
);

    import kbd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       port;
        logic       lst;
    } frame_beat_t;

    frame_beat_t owed_beats[$];

    // deframer state as seen from the input side
    logic       in_frame;
    logic       in_esc;
    logic       held_vld;
    logic [7:0] held_byte;
    logic       held_first;
    logic       any_seen;

    int n_fail;
    int n_in;
    int n_out;
    int n_frames;

    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0] v;
        if (b == FEND) begin
            // closing FEND releases the held byte as last; empty frame gives nothing
            if (in_frame && held_vld)
                owed_beats.push_back('{held_byte, held_first, 1'b1});
            in_frame   = !in_frame;
            held_vld   = 1'b0;
            held_byte  = 8'h00;
            held_first = 1'b0;
            any_seen   = 1'b0;
            in_esc     = 1'b0;
        end
        else if (in_frame) begin
            if (b == FESC) begin
                in_esc = 1'b1;
            end
            else begin
                v = b;
                if (in_esc) begin
                    if (b == TFEND)
                        v = FEND;
                    else if (b == TFESC)
                        v = FESC;
                    in_esc = 1'b0;
                end
                if (held_vld)
                    owed_beats.push_back('{held_byte, held_first, 1'b0});
                held_byte  = v;
                held_first = !any_seen;
                any_seen   = 1'b1;
                held_vld   = 1'b1;
            end
        end
    endtask

    task automatic check_beat();
        frame_beat_t exp_beat;
        if (owed_beats.size() == 0) begin
            $display("%0t: unexpected beat frame_byte=%02h is_port=%0b last=%0b",
                     $time, frame_byte, is_port, last);
            n_fail++;
        end
        else begin
            exp_beat = owed_beats.pop_front();
            if (frame_byte !== exp_beat.data) begin
                $display("%0t: frame_byte expected %02h actual %02h",
                         $time, exp_beat.data, frame_byte);
                n_fail++;
            end
            if (is_port !== exp_beat.port) begin
                $display("%0t: is_port expected %0b actual %0b (byte %02h)",
                         $time, exp_beat.port, is_port, exp_beat.data);
                n_fail++;
            end
            if (last !== exp_beat.lst) begin
                $display("%0t: last expected %0b actual %0b (byte %02h)",
                         $time, exp_beat.lst, last, exp_beat.data);
                n_fail++;
            end
        end
        n_out++;
        if (last === 1'b1)
            n_frames++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            owed_beats.delete();
            in_frame   = 1'b0;
            in_esc     = 1'b0;
            held_vld   = 1'b0;
            held_byte  = 8'h00;
            held_first = 1'b0;
            any_seen   = 1'b0;
            n_fail     = 0;
            n_in       = 0;
            n_out      = 0;
            n_frames   = 0;
            fail_count <= 0;
            pending    <= 0;
            bytes_in   <= 0;
            bytes_out  <= 0;
            frames_out <= 0;
        end
        else begin
            if (in_valid && !in_stall) begin
                deframe_byte(rx_byte);
                n_in++;
            end
            if (out_valid && !out_stall)
                check_beat();
            fail_count <= n_fail;
            pending    <= owed_beats.size();
            bytes_in   <= n_in;
            bytes_out  <= n_out;
            frames_out <= n_frames;
        end
    end

endmodule

[dv/tb_kiss_byte_deframer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kiss_byte_deframer
// Drives KISS-framed byte streams into the deframer: a directed opener with
// escapes, empty and single-byte frames and stray bytes, then random frames,
// noise and cut-off escapes, with random idle and stall on both sides.
// ----------------------------------------------------------------------------
module tb_kiss_byte_deframer;

    import kbd_pkg::*;

    localparam int N_ITEMS    = 1100;
    localparam int IDLE_PCT   = 33;
    localparam int STALL_LIM  = 2000;
    localparam int N_DIRECTED = 26;
    localparam int DRAIN_CYC  = 10;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] frame_byte;
    logic       is_port;
    logic       last;

    logic       quiet     = 1'b0;
    int         fail_count;
    int         pending;
    int         bytes_in;
    int         bytes_out;
    int         frames_out;
    int         n_sent;
    int         idle_run  = 0;

    // escapes of both kinds, escaped plain byte, FESC FESC, empty and one-byte
    // frames, stray bytes outside a frame, FEND cutting an escape short
    logic [7:0] directed [N_DIRECTED] = '{
        FEND, 8'h00, 8'hFF, FESC, TFEND, FESC, TFESC, FESC, 8'h41,
        FESC, FESC, TFEND, TFEND, TFESC, FEND,
        FEND, FEND,
        FEND, 8'h55, FEND,
        8'h12, FESC,
        FEND, 8'h01, FESC, FEND
    };

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    kiss_byte_deframer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .is_port    (is_port),
        .last       (last)
    );

    kbd_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .is_port    (is_port),
        .last       (last),
        .fail_count (fail_count),
        .pending    (pending),
        .bytes_in   (bytes_in),
        .bytes_out  (bytes_out),
        .frames_out (frames_out)
    );

    always @(posedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // no beat on either side for too long means a hang
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= STALL_LIM) begin
            $display("%0t: timeout, no beat for %0d cycles, %0d frame bytes owed",
                     $time, idle_run, pending);
            $display("tb_kiss_byte_deframer NOT OK");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!quiet && ($urandom_range(0, 99) < IDLE_PCT)) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    function automatic logic [7:0] any_but_fend();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == FEND)
            b = 8'($urandom_range(0, 191));
        return b;
    endfunction

    // opening FEND, len content bytes, optional cut-off escape, closing FEND
    task automatic send_frame(input int len, input bit cut_escape);
        int pick;
        send_byte(FEND);
        n_sent++;
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_byte(any_but_fend());
                n_sent++;
            end
            else begin
                send_byte(FESC);
                if (pick < 85)
                    send_byte(TFEND);
                else if (pick < 95)
                    send_byte(TFESC);
                else
                    send_byte(FESC);
                n_sent += 2;
            end
        end
        if (cut_escape) begin
            send_byte(FESC);
            n_sent++;
        end
        send_byte(FEND);
        n_sent++;
    endtask

    initial
    begin
        int pick;
        int len;
        n_sent   = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_byte(directed[i]);

        while (n_sent < N_ITEMS) begin
            quiet <= (n_sent >= 450 && n_sent < 700);
            pick = $urandom_range(0, 99);
            if (pick < 5)
                len = $urandom_range(20, 40);
            else if (pick < 10)
                len = 0;
            else
                len = $urandom_range(1, 8);
            pick = $urandom_range(0, 99);
            if (pick < 82) begin
                send_frame(len, 1'b0);
            end
            else if (pick < 92) begin
                // stray bytes between frames, ignored by the block
                repeat ($urandom_range(1, 4))
                    send_byte(any_but_fend());
            end
            else begin
                send_frame(len, 1'b1);
            end
        end
        in_valid <= 1'b0;
        quiet    <= 1'b0;
        // let the count from the last input beat settle
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Summary: %0d bytes in, %0d frame bytes checked, %0d frames closed",
                 bytes_in, bytes_out, frames_out);
        if (fail_count == 0)
            $display("tb_kiss_byte_deframer OK");
        else
            $display("tb_kiss_byte_deframer NOT OK");
        $finish;
    end

endmodule

[kiss_byte_deframer.f]
design/kbd_pkg.sv
design/kbd_in_stage.sv
design/kbd_core.sv
design/kbd_out_stage.sv
design/kiss_byte_deframer.sv
design/kbd_checker.sv
dv/kbd_checker.sv
dv/tb_kiss_byte_deframer.sv
